// ----- sv/tiex_pkg.sv -----
package tiex_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;
    localparam int WORD_W    = 32;
    localparam int PC_W      = 16;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_STEP  = 2'd1;
    localparam logic [1:0] REQ_MREAD = 2'd2;
    localparam logic [1:0] REQ_RREAD = 2'd3;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_NOR  = 3'd1;
    localparam logic [2:0] OP_LW   = 3'd2;
    localparam logic [2:0] OP_SW   = 3'd3;
    localparam logic [2:0] OP_BEQ  = 3'd4;
    localparam logic [2:0] OP_JALR = 3'd5;
    localparam logic [2:0] OP_HALT = 3'd6;
    localparam logic [2:0] OP_NOOP = 3'd7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        address;
        logic signed [31:0] load_data;
    } req_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               halted;
        logic signed [31:0] read_value;
        logic [2:0]         executed_opcode;
    } rsp_t;

endpackage

// ----- sv/tiex_ram.sv -----
module tiex_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/tiny_isa_instruction_executor_top.sv -----
// Load word: written at the accepting edge, then a registered result strobe. Memory or register
// read: ST_MRD or ST_RRD. Step: ST_FETCH, ST_RDA and ST_RDB for add, nor, beq, jalr, halt and noop,
// then ST_EA for sw and ST_EA and ST_LWD for lw, set by the fetch and the two register reads
// through synchronous memories with one read port each; a step while halted is ignored.
// One word at a time: busy stays high until the result strobe; the receiver cannot stall.
// Reset clears the program counter, the halt flag and all registers; memory is undefined.
module tiny_isa_instruction_executor_top #(
    parameter int MEM_WORDS = 65536
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  tiex_pkg::req_t req,
    output logic          done,
    output tiex_pkg::rsp_t rsp
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [23:0] MEM_WORDS_24 = 24'(MEM_WORDS);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MRD   = 8'b0000_0010,
        ST_RRD   = 8'b0000_0100,
        ST_FETCH = 8'b0000_1000,
        ST_RDA   = 8'b0001_0000,
        ST_RDB   = 8'b0010_0000,
        ST_EA    = 8'b0100_0000,
        ST_LWD   = 8'b1000_0000
    } state_t;

    // Quotient of a 16-bit address by MEM_WORDS (at least 256) fits in eight bits,
    // so eight restoring compare-subtract steps leave the remainder.
    function automatic logic [AW-1:0] mem_index(input logic [15:0] a);
        logic [23:0] r;
        r = {8'd0, a};
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= (MEM_WORDS_24 << k))
            begin
                r = r - (MEM_WORDS_24 << k);
            end
        end
        return r[AW-1:0];
    endfunction

    state_t                               state_reg, state_next;
    logic [tiex_pkg::PC_W-1:0]            pc_reg, pc_next;
    logic                                 halt_reg, halt_next;
    logic [tiex_pkg::REG_COUNT-1:0]       rvalid_reg, rvalid_next;
    logic                                 rf_hit_reg, rf_hit_next;
    logic [tiex_pkg::WORD_W-1:0]          instr_reg, instr_next;
    logic [tiex_pkg::WORD_W-1:0]          a_reg, a_next;
    logic [tiex_pkg::WORD_W-1:0]          b_reg, b_next;
    logic [15:0]                          ea_reg, ea_next;
    logic                                 done_reg, done_next;
    tiex_pkg::rsp_t                       rsp_reg, rsp_next;

    logic                                 mem_we;
    logic [AW-1:0]                        mem_waddr, mem_raddr;
    logic [tiex_pkg::WORD_W-1:0]          mem_wdata, mem_rdata;

    logic                                 rf_we;
    logic [tiex_pkg::REG_IDX_W-1:0]       rf_waddr, rf_raddr;
    logic [tiex_pkg::WORD_W-1:0]          rf_wdata, rf_rdata, rf_val;

    logic                                 fin;
    logic [tiex_pkg::WORD_W-1:0]          rv;
    logic [2:0]                           opc, op;
    logic [tiex_pkg::PC_W-1:0]            pc1;

    tiex_ram #(
        .WIDTH(tiex_pkg::WORD_W),
        .DEPTH(MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tiex_ram #(
        .WIDTH(tiex_pkg::WORD_W),
        .DEPTH(tiex_pkg::REG_COUNT)
    ) u_regs (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    // A register never written since reset reads as zero.
    assign rf_val = rf_hit_reg ? rf_rdata : '0;
    assign op     = instr_reg[24:22];
    assign pc1    = pc_reg + 16'd1;

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        halt_next   = halt_reg;
        rvalid_next = rvalid_reg;
        rf_hit_next = rf_hit_reg;
        instr_next  = instr_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        ea_next     = ea_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;
        rf_we       = 1'b0;
        rf_waddr    = '0;
        rf_wdata    = '0;
        rf_raddr    = '0;
        fin         = 1'b0;
        rv          = '0;
        opc         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req.req_type)
                        tiex_pkg::REQ_LOAD:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = mem_index(req.address);
                            mem_wdata = req.load_data;
                            fin       = 1'b1;
                        end
                        tiex_pkg::REQ_STEP:
                        begin
                            if (halt_reg)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = mem_index(pc_reg);
                                state_next = ST_FETCH;
                            end
                        end
                        tiex_pkg::REQ_MREAD:
                        begin
                            mem_raddr  = mem_index(req.address);
                            state_next = ST_MRD;
                        end
                        default:
                        begin
                            rf_raddr    = req.address[2:0];
                            rf_hit_next = rvalid_reg[req.address[2:0]];
                            state_next  = ST_RRD;
                        end
                    endcase
                end
            end
            ST_MRD:
            begin
                rv         = mem_rdata;
                fin        = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RRD:
            begin
                rv         = rf_val;
                fin        = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FETCH:
            begin
                instr_next  = mem_rdata;
                rf_raddr    = mem_rdata[21:19];
                rf_hit_next = rvalid_reg[mem_rdata[21:19]];
                state_next  = ST_RDA;
            end
            ST_RDA:
            begin
                a_next      = rf_val;
                rf_raddr    = instr_reg[18:16];
                rf_hit_next = rvalid_reg[instr_reg[18:16]];
                state_next  = ST_RDB;
            end
            ST_RDB:
            begin
                state_next = ST_IDLE;
                case (op)
                    tiex_pkg::OP_ADD:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = instr_reg[2:0];
                        rf_wdata = a_reg + rf_val;
                        fin      = 1'b1;
                    end
                    tiex_pkg::OP_NOR:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = instr_reg[2:0];
                        rf_wdata = ~(a_reg | rf_val);
                        fin      = 1'b1;
                    end
                    tiex_pkg::OP_LW, tiex_pkg::OP_SW:
                    begin
                        // Only the low 16 bits of the effective address matter.
                        ea_next    = a_reg[15:0] + instr_reg[15:0];
                        b_next     = rf_val;
                        state_next = ST_EA;
                    end
                    tiex_pkg::OP_BEQ:
                    begin
                        fin     = 1'b1;
                        pc_next = (a_reg == rf_val) ? pc1 + instr_reg[15:0] : pc1;
                    end
                    tiex_pkg::OP_JALR:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = instr_reg[18:16];
                        rf_wdata = {16'd0, pc1};
                        fin      = 1'b1;
                        // With regA equal to regB the link value is the target.
                        pc_next  = (instr_reg[21:19] == instr_reg[18:16]) ? pc1 : a_reg[15:0];
                    end
                    tiex_pkg::OP_HALT:
                    begin
                        halt_next = 1'b1;
                        fin       = 1'b1;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
                if (fin && op != tiex_pkg::OP_BEQ && op != tiex_pkg::OP_JALR)
                begin
                    pc_next = pc1;
                end
                opc = op;
            end
            ST_EA:
            begin
                if (op == tiex_pkg::OP_SW)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = mem_index(ea_reg);
                    mem_wdata  = b_reg;
                    pc_next    = pc1;
                    opc        = op;
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_raddr  = mem_index(ea_reg);
                    state_next = ST_LWD;
                end
            end
            ST_LWD:
            begin
                rf_we      = 1'b1;
                rf_waddr   = instr_reg[18:16];
                rf_wdata   = mem_rdata;
                pc_next    = pc1;
                opc        = op;
                fin        = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (rf_we)
        begin
            rvalid_next[rf_waddr] = 1'b1;
        end

        done_next                = fin;
        rsp_next.next_pc         = pc_next;
        rsp_next.halted          = halt_next;
        rsp_next.read_value      = rv;
        rsp_next.executed_opcode = opc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pc_reg     <= '0;
            halt_reg   <= 1'b0;
            rvalid_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            halt_reg   <= halt_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rf_hit_reg <= rf_hit_next;
        instr_reg  <= instr_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        ea_reg     <= ea_next;
        if (fin)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- tb/sv/tb_tiny_isa_instruction_executor_top.sv -----
module tb_tiny_isa_instruction_executor_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] NO_OPCODE   = 3'd0;
    localparam int         QUIET_LIMIT = 1000;

    typedef struct {
        tiex_pkg::req_t word;
        bit             has_typed;
        tiex_pkg::rsp_t typed;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    tiex_pkg::req_t req;
    logic done;
    tiex_pkg::rsp_t rsp;

    // Machine state as the block should hold it.
    logic [31:0] memory_image [int];
    logic [31:0] regs [tiex_pkg::REG_COUNT];
    logic [15:0] pc_q;
    logic        halt_q;
    int          written_addrs [$];

    tiex_pkg::rsp_t expected_rsp_q [$];
    script_row_t    script [$];
    int             error_count = 0;
    int             words_sent = 0;
    int             quiet_cycles = 0;
    int             idle_pct = 0;

    tiny_isa_instruction_executor_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    function automatic tiex_pkg::req_t make_req(input logic [1:0] t, input logic [15:0] a,
                                                input logic [31:0] d);
        tiex_pkg::req_t w;
        w.req_type  = t;
        w.address   = a;
        w.load_data = d;
        return w;
    endfunction

    function automatic logic [31:0] encode(input logic [2:0] op, input logic [2:0] ra,
                                           input logic [2:0] rb, input logic [15:0] off);
        return {7'd0, op, ra, rb, off};
    endfunction

    function automatic logic [2:0] random_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 16) return tiex_pkg::OP_ADD;
        if (r < 30) return tiex_pkg::OP_NOR;
        if (r < 48) return tiex_pkg::OP_LW;
        if (r < 64) return tiex_pkg::OP_SW;
        if (r < 80) return tiex_pkg::OP_BEQ;
        if (r < 90) return tiex_pkg::OP_JALR;
        return tiex_pkg::OP_NOOP;
    endfunction

    function automatic logic [31:0] random_instr(input logic [2:0] op);
        logic [31:0] w;
        w = $urandom();
        w[24:22] = op;
        if (op == tiex_pkg::OP_BEQ)
        begin
            // Short branches keep execution inside the loaded code and form loops.
            if ($urandom_range(2) != 0)
                w[15:0] = 16'($urandom_range(8)) - 16'd4;
            if ($urandom_range(2) == 0)
                w[18:16] = w[21:19];
        end
        return w;
    endfunction

    function automatic void store_word(input logic [15:0] a, input logic [31:0] d);
        memory_image[int'(a)] = d;
        written_addrs.push_back(int'(a));
    endfunction

    function automatic logic [31:0] fetch_word(input logic [15:0] a);
        if (memory_image.exists(int'(a)))
            return memory_image[int'(a)];
        return 32'd0;
    endfunction

    function automatic tiex_pkg::rsp_t execute_request(input tiex_pkg::req_t w);
        tiex_pkg::rsp_t r;
        logic [31:0]    instr;
        logic [31:0]    off;
        logic [2:0]     op;
        logic [2:0]     ra;
        logic [2:0]     rb;
        logic [2:0]     rd;
        logic [15:0]    nxt;
        r = '0;
        case (w.req_type)
            tiex_pkg::REQ_LOAD: store_word(w.address, w.load_data);
            tiex_pkg::REQ_STEP:
                if (!halt_q)
                begin
                    instr = fetch_word(pc_q);
                    op    = instr[24:22];
                    ra    = instr[21:19];
                    rb    = instr[18:16];
                    rd    = instr[2:0];
                    off   = {{16{instr[15]}}, instr[15:0]};
                    nxt   = pc_q + 16'd1;
                    case (op)
                        tiex_pkg::OP_ADD:  regs[rd] = regs[ra] + regs[rb];
                        tiex_pkg::OP_NOR:  regs[rd] = ~(regs[ra] | regs[rb]);
                        tiex_pkg::OP_LW:   regs[rb] = fetch_word(16'(regs[ra] + off));
                        tiex_pkg::OP_SW:   store_word(16'(regs[ra] + off), regs[rb]);
                        tiex_pkg::OP_BEQ:
                            if (regs[ra] == regs[rb])
                                nxt = pc_q + 16'd1 + off[15:0];
                        tiex_pkg::OP_JALR:
                        begin
                            // The link is written first, so regA equal to regB falls through.
                            regs[rb] = {16'd0, nxt};
                            nxt = regs[ra][15:0];
                        end
                        tiex_pkg::OP_HALT: halt_q = 1'b1;
                        default: ;
                    endcase
                    pc_q = nxt;
                    r.executed_opcode = op;
                end
            tiex_pkg::REQ_MREAD: r.read_value = fetch_word(w.address);
            default:             r.read_value = regs[w.address[2:0]];
        endcase
        r.next_pc = pc_q;
        r.halted  = halt_q;
        return r;
    endfunction

    // Called at a rising edge; returns at the rising edge that accepts the word.
    task automatic send_word(input tiex_pkg::req_t w, input bit has_typed = 1'b0,
                             input tiex_pkg::rsp_t typed = '0);
        bit             taken;
        tiex_pkg::rsp_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= w;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end while (!taken);
        predicted = execute_request(w);
        expected_rsp_q.push_back(has_typed ? typed : predicted);
        words_sent++;
    endtask

    // Makes sure the fetch, and a load word's data, only touch written memory.
    task automatic step_once();
        logic [31:0] instr;
        logic [15:0] ea;
        if (!memory_image.exists(int'(pc_q)))
            send_word(make_req(tiex_pkg::REQ_LOAD, pc_q, random_instr(random_op())));
        instr = memory_image[int'(pc_q)];
        if (!halt_q && instr[24:22] == tiex_pkg::OP_LW)
        begin
            ea = 16'(regs[instr[21:19]] + {{16{instr[15]}}, instr[15:0]});
            if (!memory_image.exists(int'(ea)))
                send_word(make_req(tiex_pkg::REQ_LOAD, ea, 32'($urandom)));
        end
        send_word(make_req(tiex_pkg::REQ_STEP, 16'($urandom), 32'($urandom)));
    endtask

    task automatic random_request();
        int unsigned r;
        int          n;
        logic [15:0] base;
        r = $urandom_range(99);
        if (r < 35)
        begin
            // A short program at the current pc, then run through it.
            n    = $urandom_range(2, 8);
            base = pc_q;
            for (int i = 0; i < n; i++)
                send_word(make_req(tiex_pkg::REQ_LOAD, base + 16'(i),
                                   random_instr(random_op())));
            repeat ($urandom_range(n, 2 * n)) step_once();
        end
        else if (r < 50)
        begin
            step_once();
        end
        else if (r < 65)
        begin
            send_word(make_req(tiex_pkg::REQ_LOAD, 16'($urandom), 32'($urandom)));
        end
        else if (r < 80)
        begin
            send_word(make_req(tiex_pkg::REQ_MREAD,
                               16'(written_addrs[$urandom_range(written_addrs.size() - 1)]),
                               32'($urandom)));
        end
        else
        begin
            send_word(make_req(tiex_pkg::REQ_RREAD, 16'($urandom), 32'($urandom)));
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        tiex_pkg::rsp_t exp_rsp;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %p", $time, rsp);
                    error_count++;
                end
                else
                begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (rsp.next_pc !== exp_rsp.next_pc)
                    begin
                        $display("%0t: next_pc expected %h actual %h",
                                 $time, exp_rsp.next_pc, rsp.next_pc);
                        error_count++;
                    end
                    if (rsp.halted !== exp_rsp.halted)
                    begin
                        $display("%0t: halted expected %b actual %b",
                                 $time, exp_rsp.halted, rsp.halted);
                        error_count++;
                    end
                    if (rsp.read_value !== exp_rsp.read_value)
                    begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, exp_rsp.read_value, rsp.read_value);
                        error_count++;
                    end
                    if (rsp.executed_opcode !== exp_rsp.executed_opcode)
                    begin
                        $display("%0t: executed_opcode expected %0d actual %0d",
                                 $time, exp_rsp.executed_opcode, rsp.executed_opcode);
                        error_count++;
                    end
                end
            end
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int phase_idle [4];
        int phase_end [4];
        rst_n  = 1'b0;
        start  = 1'b0;
        req    = '0;
        pc_q   = '0;
        halt_q = 1'b0;
        foreach (regs[i])
            regs[i] = '0;
        phase_idle = '{0, 66, 0, 18};
        phase_end  = '{260, 500, 700, 930};

        // Reset values, memory extremes, then a program that uses every opcode but halt:
        // register zero written, wrapped load address, jump and link onto itself,
        // a taken branch that wraps the pc below zero and a pc increment that wraps up.
        script.push_back('{make_req(tiex_pkg::REQ_RREAD, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
                           '{16'h0000, 1'b0, 32'h0000_0000, NO_OPCODE}});
        script.push_back('{make_req(tiex_pkg::REQ_LOAD, 16'hFFFF, 32'h7FFF_FFFF), 1'b1,
                           '{16'h0000, 1'b0, 32'h0000_0000, NO_OPCODE}});
        script.push_back('{make_req(tiex_pkg::REQ_LOAD, 16'h8000, 32'h8000_0000), 1'b1,
                           '{16'h0000, 1'b0, 32'h0000_0000, NO_OPCODE}});
        script.push_back('{make_req(tiex_pkg::REQ_MREAD, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
                           '{16'h0000, 1'b0, 32'h7FFF_FFFF, NO_OPCODE}});
        script.push_back('{make_req(tiex_pkg::REQ_MREAD, 16'h8000, 32'h0000_0000), 1'b1,
                           '{16'h0000, 1'b0, 32'h8000_0000, NO_OPCODE}});
        script.push_back('{make_req(tiex_pkg::REQ_LOAD, 16'd0,
                                    encode(tiex_pkg::OP_LW, 3'd0, 3'd0, 16'hFFFF)),
                           1'b0, '0});
        script.push_back('{make_req(tiex_pkg::REQ_LOAD, 16'd1,
                                    encode(tiex_pkg::OP_LW, 3'd0, 3'd1, 16'h8001)),
                           1'b0, '0});
        script.push_back('{make_req(tiex_pkg::REQ_LOAD, 16'd2,
                                    encode(tiex_pkg::OP_ADD, 3'd0, 3'd1, 16'h0002)),
                           1'b0, '0});
        script.push_back('{make_req(tiex_pkg::REQ_LOAD, 16'd3,
                                    encode(tiex_pkg::OP_NOR, 3'd0, 3'd1, 16'h0003)),
                           1'b0, '0});
        script.push_back('{make_req(tiex_pkg::REQ_LOAD, 16'd4,
                                    encode(tiex_pkg::OP_SW, 3'd3, 3'd2, 16'h0100)),
                           1'b0, '0});
        script.push_back('{make_req(tiex_pkg::REQ_LOAD, 16'd5,
                                    encode(tiex_pkg::OP_BEQ, 3'd0, 3'd1, 16'h7FFF)),
                           1'b0, '0});
        script.push_back('{make_req(tiex_pkg::REQ_LOAD, 16'd6,
                                    encode(tiex_pkg::OP_JALR, 3'd4, 3'd4, 16'h0000)),
                           1'b0, '0});
        script.push_back('{make_req(tiex_pkg::REQ_LOAD, 16'd7,
                                    encode(tiex_pkg::OP_BEQ, 3'd3, 3'd3, 16'hFFF7)),
                           1'b0, '0});
        repeat (9)
            script.push_back('{make_req(tiex_pkg::REQ_STEP, 16'($urandom), 32'($urandom)),
                               1'b0, '0});
        script.push_back('{make_req(tiex_pkg::REQ_MREAD, 16'h0100, 32'h0), 1'b0, '0});
        script.push_back('{make_req(tiex_pkg::REQ_RREAD, 16'h0004, 32'h0), 1'b0, '0});
        script.push_back('{make_req(tiex_pkg::REQ_RREAD, 16'hFFF8, 32'h0), 1'b0, '0});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_word(script[i].word, script[i].has_typed, script[i].typed);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            while (words_sent < phase_end[p])
                random_request();
            drain();
        end

        // Halting is permanent, so it closes the run; later steps must be ignored.
        send_word(make_req(tiex_pkg::REQ_LOAD, pc_q, random_instr(tiex_pkg::OP_HALT)));
        step_once();
        repeat (12) random_request();
        drain();

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- tiny_isa_instruction_executor_top.f -----
sv/tiex_pkg.sv
sv/tiex_ram.sv
sv/tiny_isa_instruction_executor_top.sv
tb/sv/tb_tiny_isa_instruction_executor_top.sv
